@@ rtl/core/rwcp_pkg.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser package
// Shared types, tag constants and an offset helper for the byte-serial header walker.
// ----------------------------------------------------------------------------
package rwcp_pkg;

    localparam int OFFSET_WIDTH = 32;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN  = 32'd14;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_RLEN = 3'd1,
        PH_WAVE = 3'd2,
        PH_CTAG = 3'd3,
        PH_CLEN = 3'd4,
        PH_SKIP = 3'd5,
        PH_IDLE = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NOT_RIFF      = 3'd1,
        ST_NOT_WAVE      = 3'd2,
        ST_FMT_SHORT     = 3'd3,
        ST_CHUNK_MISSING = 3'd4,
        ST_TRUNCATED     = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_byte;
    } feed_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] format_offset;
        logic [31:0] data_offset;
        logic [31:0] data_length;
    } report_t;

    typedef struct packed {
        logic    hit;
        report_t item;
    } step_out_t;

    // Keeps the low OFFSET_WIDTH bits of a byte count, zero extended.
    function automatic logic [31:0] offset_of(input logic [32:0] pos);
        logic [31:0] r;
        r = '0;
        r[OFFSET_WIDTH-1:0] = pos[OFFSET_WIDTH-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/rwcp_walker.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk walker
// Holds the parse state and consumes one registered byte per step.
// ----------------------------------------------------------------------------
module rwcp_walker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  rwcp_pkg::feed_t      feed,
    output rwcp_pkg::step_out_t  result
);
    import rwcp_pkg::*;

    phase_t      phase_reg,         phase_next;
    logic [23:0] field_shift_reg,   field_shift_next;
    logic [1:0]  byte_in_field_reg, byte_in_field_next;
    logic [32:0] position_reg,      position_next;
    logic [32:0] walk_end_reg,      walk_end_next;
    logic [31:0] chunk_tag_reg,     chunk_tag_next;
    logic [32:0] skip_left_reg,     skip_left_next;
    logic        format_found_reg,  format_found_next;
    logic [31:0] format_at_reg,     format_at_next;
    logic [31:0] data_at_reg,       data_at_next;
    logic [31:0] data_size_reg,     data_size_next;

    logic [32:0] pos;
    logic        header_late;
    logic [31:0] word;
    logic [32:0] skip_len;
    logic [32:0] skip_dec;
    logic        have;
    status_t     status;

    assign pos         = (position_reg == '1) ? position_reg : position_reg + 33'd1;
    assign header_late = (pos >= walk_end_reg);
    assign word        = {feed.file_byte, field_shift_reg};
    assign skip_len    = ({1'b0, word} + 33'd1) & ~33'd1;
    assign skip_dec    = (skip_left_reg != '0) ? skip_left_reg - 33'd1 : skip_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_RIFF;
            field_shift_reg   <= '0;
            byte_in_field_reg <= '0;
            position_reg      <= '0;
            walk_end_reg      <= '0;
            chunk_tag_reg     <= '0;
            skip_left_reg     <= '0;
            format_found_reg  <= 1'b0;
            format_at_reg     <= '0;
            data_at_reg       <= '0;
            data_size_reg     <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            field_shift_reg   <= field_shift_next;
            byte_in_field_reg <= byte_in_field_next;
            position_reg      <= position_next;
            walk_end_reg      <= walk_end_next;
            chunk_tag_reg     <= chunk_tag_next;
            skip_left_reg     <= skip_left_next;
            format_found_reg  <= format_found_next;
            format_at_reg     <= format_at_next;
            data_at_reg       <= data_at_next;
            data_size_reg     <= data_size_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        field_shift_next   = field_shift_reg;
        byte_in_field_next = byte_in_field_reg;
        position_next      = position_reg;
        walk_end_next      = walk_end_reg;
        chunk_tag_next     = chunk_tag_reg;
        skip_left_next     = skip_left_reg;
        format_found_next  = format_found_reg;
        format_at_next     = format_at_reg;
        data_at_next       = data_at_reg;
        data_size_next     = data_size_reg;
        have               = 1'b0;
        status             = ST_OK;

        if (step)
        begin
            position_next = pos;
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_SKIP:
                begin
                    skip_left_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        if (header_late)
                        begin
                            have   = 1'b1;
                            status = ST_CHUNK_MISSING;
                        end
                        else
                        begin
                            phase_next = PH_CTAG;
                        end
                    end
                end
                PH_RIFF, PH_RLEN, PH_WAVE, PH_CTAG, PH_CLEN:
                begin
                    byte_in_field_next = byte_in_field_reg + 2'd1;
                    if (byte_in_field_reg != 2'd3)
                    begin
                        field_shift_next[{byte_in_field_reg, 3'b000} +: 8] = feed.file_byte;
                    end
                    else
                    begin
                        field_shift_next = '0;
                        unique case (phase_reg)
                            PH_RIFF:
                            begin
                                if (word != TAG_RIFF)
                                begin
                                    have   = 1'b1;
                                    status = ST_NOT_RIFF;
                                end
                                else
                                begin
                                    phase_next = PH_RLEN;
                                end
                            end
                            PH_RLEN:
                            begin
                                walk_end_next = {1'b0, word} + 33'd8;
                                phase_next    = PH_WAVE;
                            end
                            PH_WAVE:
                            begin
                                if (word != TAG_WAVE)
                                begin
                                    have   = 1'b1;
                                    status = ST_NOT_WAVE;
                                end
                                else if (header_late)
                                begin
                                    have   = 1'b1;
                                    status = ST_CHUNK_MISSING;
                                end
                                else
                                begin
                                    phase_next = PH_CTAG;
                                end
                            end
                            PH_CTAG:
                            begin
                                chunk_tag_next = word;
                                phase_next     = PH_CLEN;
                            end
                            default:
                            begin
                                if (chunk_tag_reg == TAG_FMT && !format_found_reg)
                                begin
                                    if (word < FMT_MIN)
                                    begin
                                        have   = 1'b1;
                                        status = ST_FMT_SHORT;
                                    end
                                    else
                                    begin
                                        format_found_next = 1'b1;
                                        format_at_next    = offset_of(pos);
                                        if (data_at_reg != '0 && data_size_reg != '0)
                                        begin
                                            have   = 1'b1;
                                            status = ST_OK;
                                        end
                                    end
                                end
                                else if (chunk_tag_reg == TAG_DATA &&
                                         (data_at_reg == '0 || data_size_reg == '0))
                                begin
                                    data_at_next   = offset_of(pos);
                                    data_size_next = word;
                                    if (format_found_reg)
                                    begin
                                        have   = 1'b1;
                                        status = ST_OK;
                                    end
                                end
                                if (!have)
                                begin
                                    skip_left_next = skip_len;
                                    if (skip_len == '0)
                                    begin
                                        if (header_late)
                                        begin
                                            have   = 1'b1;
                                            status = ST_CHUNK_MISSING;
                                        end
                                        else
                                        begin
                                            phase_next = PH_CTAG;
                                        end
                                    end
                                    else
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase

            if (!have && feed.last_byte && phase_reg != PH_IDLE)
            begin
                have   = 1'b1;
                status = ST_TRUNCATED;
            end
            if (have)
            begin
                phase_next = PH_IDLE;
            end
        end

        result.hit                = step && have;
        result.item.status        = status;
        result.item.format_offset = (status == ST_OK) ? format_at_next : '0;
        result.item.data_offset   = (status == ST_OK) ? data_at_next : '0;
        result.item.data_length   = (status == ST_OK) ? data_size_next : '0;

        // The final byte always leaves the walker ready for the next file.
        if (step && feed.last_byte)
        begin
            phase_next         = PH_RIFF;
            field_shift_next   = '0;
            byte_in_field_next = '0;
            position_next      = '0;
            walk_end_next      = '0;
            chunk_tag_next     = '0;
            skip_left_next     = '0;
            format_found_next  = 1'b0;
            format_at_next     = '0;
            data_at_next       = '0;
            data_size_next     = '0;
        end
    end

    a_hit_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.hit && !feed.last_byte |=> phase_reg == PH_IDLE)
        else $error("walker did not go idle after a result");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && feed.last_byte |=> phase_reg == PH_RIFF && position_reg == '0)
        else $error("walker did not restart after the final byte");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_left_reg != '0)
        else $error("skip phase entered with nothing to skip");

    a_ok_has_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        result.hit && result.item.status == ST_OK |-> format_found_next || feed.last_byte)
        else $error("ok result without a fmt chunk");

endmodule

@@ rtl/core/riff_wave_chunk_parser.sv @@
// A byte is held in the input register; its result is captured in the result register.
// Throughput: one byte per cycle, the walker stepping from the input register.
// A result waiting in the output register stalls the walker only when it is not taken.
// Reset (rst_n, asynchronous, active low) empties both registers and restarts the
// walker at the RIFF tag; the final-byte marker also restarts it for the next file.
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser
// Byte-serial wave header walker with an input register and a result register.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              feed_valid,
    output logic              feed_ready,
    input  rwcp_pkg::feed_t   feed,
    output logic              report_valid,
    input  logic              report_ready,
    output rwcp_pkg::report_t report
);
    import rwcp_pkg::*;

    logic      in_valid_reg;
    feed_t     in_item_reg;
    logic      out_valid_reg;
    report_t   out_item_reg;
    logic      advance;
    step_out_t step_res;

    // The walker steps when the result slot is free or is being emptied now.
    assign advance    = in_valid_reg && (!out_valid_reg || report_ready);
    assign feed_ready = !in_valid_reg || advance;

    rwcp_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .feed   (in_item_reg),
        .result (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (feed_ready)
            begin
                in_valid_reg <= feed_valid;
            end
            if (advance && step_res.hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_valid && feed_ready)
        begin
            in_item_reg <= feed;
        end
        if (advance && step_res.hit)
        begin
            out_item_reg <= step_res.item;
        end
    end

    assign report_valid = out_valid_reg;
    assign report       = out_item_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !report_ready |=> !$past(step_res.hit && advance))
        else $error("pending result overwritten");

endmodule
